[hw/rtl/wstt_pkg.sv]
// Shared types, constants and split tables for the wedge-to-tetrahedra splitter.
package wstt_pkg;

  localparam int IdW        = 31;
  localparam int NumCorners = 6;
  localparam int TetW       = 2;
  localparam int SelW       = 3;
  localparam int CornerW    = 3;
  localparam int QueueDepth = 2;

  localparam logic [TetW-1:0] FirstTet = 2'd0;
  localparam logic [TetW-1:0] LastTet  = 2'd2;

  // Face-bit codes with no valid split (all three diagonals turn the same way)
  localparam logic [SelW-1:0] SelAllEven = 3'b000;
  localparam logic [SelW-1:0] SelAllOdd  = 3'b111;

  typedef struct packed {
    logic [IdW-1:0] corner_0;
    logic [IdW-1:0] corner_1;
    logic [IdW-1:0] corner_2;
    logic [IdW-1:0] corner_3;
    logic [IdW-1:0] corner_4;
    logic [IdW-1:0] corner_5;
    logic           is_wedge;
  } item_t;

  typedef struct packed {
    logic            split_ok;
    logic [TetW-1:0] tet_number;
    logic [IdW-1:0]  vertex_a;
    logic [IdW-1:0]  vertex_b;
    logic [IdW-1:0]  vertex_c;
    logic [IdW-1:0]  vertex_d;
    logic            last;
  } result_t;

  // Classified wedge passed from the front to the back
  typedef struct packed {
    logic                                ok;
    logic [SelW-1:0]                     sel;
    logic [NumCorners-1:0][IdW-1:0]      corner;
  } job_t;

  // Corner indexes {a, b, c, d} of one tetrahedron, a in the top bits
  function automatic logic [4*CornerW-1:0] tet_corners(input logic [SelW-1:0] sel,
                                                       input logic [TetW-1:0] tet);
    logic [4*CornerW-1:0] r;
    r = '0;
    case ({sel, tet})
      5'b001_00: r = {3'd0, 3'd4, 3'd5, 3'd3};
      5'b001_01: r = {3'd0, 3'd1, 3'd5, 3'd4};
      5'b001_10: r = {3'd0, 3'd1, 3'd2, 3'd5};
      5'b010_00: r = {3'd0, 3'd4, 3'd2, 3'd3};
      5'b010_01: r = {3'd0, 3'd1, 3'd2, 3'd4};
      5'b010_10: r = {3'd2, 3'd3, 3'd4, 3'd5};
      5'b011_00: r = {3'd0, 3'd4, 3'd5, 3'd3};
      5'b011_01: r = {3'd0, 3'd1, 3'd2, 3'd4};
      5'b011_10: r = {3'd0, 3'd4, 3'd2, 3'd5};
      5'b100_00: r = {3'd0, 3'd1, 3'd2, 3'd3};
      5'b100_01: r = {3'd1, 3'd5, 3'd3, 3'd4};
      5'b100_10: r = {3'd1, 3'd5, 3'd2, 3'd3};
      5'b101_00: r = {3'd0, 3'd1, 3'd5, 3'd3};
      5'b101_01: r = {3'd1, 3'd5, 3'd3, 3'd4};
      5'b101_10: r = {3'd0, 3'd1, 3'd2, 3'd5};
      5'b110_00: r = {3'd0, 3'd1, 3'd2, 3'd3};
      5'b110_01: r = {3'd1, 3'd4, 3'd2, 3'd3};
      5'b110_10: r = {3'd2, 3'd3, 3'd4, 3'd5};
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/wstt_front.sv]
// Front stage: takes a wedge, picks the face diagonals and registers the classified job.
module wstt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  wstt_pkg::item_t  item,
  output logic             push,
  input  logic             push_ready,
  output wstt_pkg::job_t   job
);

  logic valid;

  // Set when the smallest id of a quad face sits at an odd position; first one wins ties
  function automatic logic face_odd(input logic [wstt_pkg::IdW-1:0] a0,
                                    input logic [wstt_pkg::IdW-1:0] a1,
                                    input logic [wstt_pkg::IdW-1:0] a2,
                                    input logic [wstt_pkg::IdW-1:0] a3);
    logic p1;
    logic p3;
    p1 = (a1 < a0) && (a1 <= a2) && (a1 <= a3);
    p3 = (a3 < a0) && (a3 < a1) && (a3 < a2);
    return p1 | p3;
  endfunction

  logic [wstt_pkg::SelW-1:0] sel;
  wstt_pkg::job_t            job_next;

  always_comb begin
    sel[2] = face_odd(item.corner_0, item.corner_1, item.corner_4, item.corner_3);
    sel[1] = face_odd(item.corner_1, item.corner_2, item.corner_5, item.corner_4);
    sel[0] = face_odd(item.corner_2, item.corner_0, item.corner_3, item.corner_5);
    job_next.sel       = sel;
    job_next.ok        = item.is_wedge && (sel != wstt_pkg::SelAllEven)
                         && (sel != wstt_pkg::SelAllOdd);
    job_next.corner[0] = item.corner_0;
    job_next.corner[1] = item.corner_1;
    job_next.corner[2] = item.corner_2;
    job_next.corner[3] = item.corner_3;
    job_next.corner[4] = item.corner_4;
    job_next.corner[5] = item.corner_5;
  end

  // Hold the stage while the queue is full
  assign busy = valid && !push_ready;
  assign push = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (start && !busy) begin
      valid <= 1'b1;
    end else if (push_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      job <= job_next;
    end
  end

endmodule

[hw/rtl/wstt_queue.sv]
// Short job queue between the front and back stages.
module wstt_queue #(
  parameter int DEPTH = wstt_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  wstt_pkg::job_t push_job,
  input  logic           pop,
  output logic           head_valid,
  output wstt_pkg::job_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  wstt_pkg::job_t store [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_job;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[hw/rtl/wstt_back.sv]
// Back stage: walks a job through its tetrahedra and registers one result beat per cycle while a job is queued.
module wstt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  wstt_pkg::job_t    head,
  output logic              pop,
  output logic              done,
  output wstt_pkg::result_t result
);

  logic [wstt_pkg::TetW-1:0]      cnt;
  logic [4*wstt_pkg::CornerW-1:0] idx;
  logic                           final_beat;
  wstt_pkg::result_t              result_next;

  assign idx        = wstt_pkg::tet_corners(head.sel, cnt);
  assign final_beat = !head.ok || (cnt == wstt_pkg::LastTet);
  assign pop        = head_valid && final_beat;

  always_comb begin
    result_next = '0;
    result_next.last = final_beat;
    if (head.ok) begin
      result_next.split_ok   = 1'b1;
      result_next.tet_number = cnt;
      result_next.vertex_a   = head.corner[idx[4*wstt_pkg::CornerW-1 -: wstt_pkg::CornerW]];
      result_next.vertex_b   = head.corner[idx[3*wstt_pkg::CornerW-1 -: wstt_pkg::CornerW]];
      result_next.vertex_c   = head.corner[idx[2*wstt_pkg::CornerW-1 -: wstt_pkg::CornerW]];
      result_next.vertex_d   = head.corner[idx[wstt_pkg::CornerW-1 -: wstt_pkg::CornerW]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= wstt_pkg::FirstTet;
      done <= 1'b0;
    end else begin
      done <= head_valid;
      if (head_valid) begin
        // Advance to the next tetrahedron, or drop the job after its final beat
        cnt <= final_beat ? wstt_pkg::FirstTet : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    (done && !result.split_ok) |-> (result.last && result.tet_number == wstt_pkg::FirstTet))
    else $error("failure beat not a single last beat");

  a_last_third: assert property (@(posedge clk) disable iff (rst)
    (done && result.split_ok) |-> (result.last == (result.tet_number == wstt_pkg::LastTet)))
    else $error("last flag out of step with tetrahedron number");

endmodule

[hw/rtl/wedge_split_into_tetrahedra.sv]
// Top level of the wedge-to-tetrahedra splitter: front, job queue and back.
//
// A wedge is taken when start is high and busy is low. A valid wedge yields three
// result beats (tetrahedra 0, 1, 2, the third with last set) on consecutive cycles;
// a non-wedge or a cyclic diagonal pattern yields one failure beat. Each beat is on
// result for one cycle with done high and must be taken then. The back stage emits
// one beat per cycle while a job is queued, so failing items can be taken one per
// cycle. The first beat of an item passes through the front register, the queue
// entry and then the result register. The front keeps taking items while the queue
// of QUEUE_DEPTH classified jobs has room; busy rises only when the front register
// holds a job the full queue cannot take.
module wedge_split_into_tetrahedra #(
  parameter int QUEUE_DEPTH = wstt_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  wstt_pkg::item_t   item,
  output logic              done,
  output wstt_pkg::result_t result
);

  logic           push;
  logic           push_ready;
  wstt_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  wstt_pkg::job_t head;

  wstt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .push       (push),
    .push_ready (push_ready),
    .job        (push_job)
  );

  wstt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  wstt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .done       (done),
    .result     (result)
  );

endmodule
